FILE: rtl/bscf_pkg.sv
// shared constants and action codes for the bitmap set/clear/find core
package bscf_pkg;

    // geometry of the store; both are powers of two
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = 16;

    // fixed field widths
    localparam int ACT_W = 4;
    localparam int IDX_W = 11;
    localparam int RES_W = 12;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET         = 4'd0,
        ACT_SET         = 4'd1,
        ACT_CLEAR       = 4'd2,
        ACT_SET_RANGE   = 4'd3,
        ACT_CLEAR_RANGE = 4'd4,
        ACT_NEXT_SET    = 4'd5,
        ACT_NEXT_CLEAR  = 4'd6,
        ACT_COUNT       = 4'd7,
        ACT_LENGTH      = 4'd8,
        ACT_CLEAR_ALL   = 4'd9
    } t_action;

endpackage

FILE: rtl/bitmap_set_clear_find_core.sv
// bitmap core: one word-wide unit swept over the store by a small sequencer
//
// A request is taken when start is high and busy is low; its one result comes
// back on the o_ ports with o_done high for exactly one cycle, and must be
// captured then because the receiver cannot hold it off. The store is 16 words
// of 64 bits. A request is first registered and then stepped through the word
// unit, which reads, masks, counts or scans one word per cycle: get, set,
// clear, clear all, unknown actions, a bad index on get, set, clear or next,
// and a bad range finish on the first word; other range updates and count
// walk all 16 words; next set and next clear walk from the start word until a
// hit or the last word; length walks down from the last word to the highest
// nonzero word or to word 0. busy drops in the same cycle as the result
// strobe, so the next request can be taken at the edge that ends that cycle.
module bitmap_set_clear_find_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [bscf_pkg::ACT_W-1:0] i_action,
    input  logic [bscf_pkg::IDX_W-1:0] i_index,
    input  logic [bscf_pkg::IDX_W-1:0] i_range_end,
    output logic                       busy,
    output logic                       o_done,
    output logic                       o_bit_value,
    output logic [bscf_pkg::RES_W-1:0] o_result_value,
    output logic                       o_error
);

    localparam int WB       = bscf_pkg::WORD_BITS;
    localparam int WC       = bscf_pkg::WORD_COUNT;
    localparam int IDX_W    = bscf_pkg::IDX_W;
    localparam int RES_W    = bscf_pkg::RES_W;
    localparam int BP_W     = $clog2(WB);
    localparam int WI_W     = $clog2(WC);
    localparam int TW_W     = IDX_W - BP_W;
    localparam int PC_W     = BP_W + 1;
    localparam int CAPACITY = WB * WC;

    localparam logic [WB-1:0]    ALL_ONES = {WB{1'b1}};
    localparam logic [WI_W-1:0]  LAST_PTR = WI_W'(WC - 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    function automatic logic [BP_W-1:0] f_low_one(input logic [WB-1:0] w);
        logic [BP_W-1:0] n;
        n = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (w[i]) n = BP_W'(i);
        end
        return n;
    endfunction

    function automatic logic [BP_W-1:0] f_high_one(input logic [WB-1:0] w);
        logic [BP_W-1:0] n;
        n = '0;
        for (int i = 0; i < WB; i++) begin
            if (w[i]) n = BP_W'(i);
        end
        return n;
    endfunction

    function automatic logic [PC_W-1:0] f_pop(input logic [WB-1:0] w);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < WB; i++) begin
            n = n + PC_W'(w[i]);
        end
        return n;
    endfunction

    t_state                r_state, n_state;
    logic [3:0]            r_act, n_act;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [IDX_W-1:0]      r_end, n_end;
    logic [WI_W-1:0]       r_ptr, n_ptr;
    logic [RES_W-1:0]      r_acc, n_acc;
    logic                  r_done, n_done;
    logic                  r_bit, n_bit;
    logic [RES_W-1:0]      r_res, n_res;
    logic                  r_err, n_err;
    logic [WB-1:0]         r_words [WC];

    logic [WB-1:0]         cur_word;
    logic                  idx_bad;
    logic                  range_bad;
    logic [WI_W-1:0]       idx_wi;
    logic [BP_W-1:0]       idx_bp;
    logic [TW_W-1:0]       from_w;
    logic [TW_W-1:0]       end_w;
    logic [BP_W-1:0]       end_bp;
    logic [TW_W-1:0]       ptr_t;
    logic [WB-1:0]         m_from;
    logic [WB-1:0]         m_to;
    logic [WB-1:0]         range_mask;
    logic [WB-1:0]         search_word;
    logic                  at_last;
    logic                  at_zero;
    logic [RES_W-1:0]      acc_sum;
    logic                  finish;
    logic                  wr_en;
    logic [WB-1:0]         wr_data;
    logic                  clr_all;

    always_comb begin
        cur_word  = r_words[r_ptr];
        idx_bad   = 32'(r_idx) >= CAPACITY;
        range_bad = (r_idx > r_end) || (32'(r_end) > CAPACITY);
        idx_wi    = r_idx[BP_W +: WI_W];
        idx_bp    = r_idx[BP_W-1:0];
        from_w    = r_idx[IDX_W-1:BP_W];
        end_w     = r_end[IDX_W-1:BP_W];
        end_bp    = r_end[BP_W-1:0];
        ptr_t     = TW_W'(r_ptr);
        at_last   = r_ptr == LAST_PTR;
        at_zero   = r_ptr == '0;

        // per-word slice of [from, to)
        if (ptr_t > from_w) begin
            m_from = ALL_ONES;
        end else if (ptr_t == from_w) begin
            m_from = ALL_ONES << idx_bp;
        end else begin
            m_from = '0;
        end
        if (ptr_t < end_w) begin
            m_to = ALL_ONES;
        end else if (ptr_t == end_w) begin
            m_to = ~(ALL_ONES << end_bp);
        end else begin
            m_to = '0;
        end
        range_mask = m_from & m_to;

        search_word = (r_act == bscf_pkg::ACT_NEXT_CLEAR) ? ~cur_word : cur_word;
        if (r_ptr == idx_wi) begin
            search_word = search_word & (ALL_ONES << idx_bp);
        end

        acc_sum = r_acc + RES_W'(f_pop(cur_word));

        n_state = r_state;
        n_act   = r_act;
        n_idx   = r_idx;
        n_end   = r_end;
        n_ptr   = r_ptr;
        n_acc   = r_acc;
        n_done  = 1'b0;
        n_bit   = r_bit;
        n_res   = r_res;
        n_err   = r_err;
        finish  = 1'b0;
        wr_en   = 1'b0;
        wr_data = cur_word;
        clr_all = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RUN;
                    n_act   = i_action;
                    n_idx   = i_index;
                    n_end   = i_range_end;
                    n_acc   = '0;
                    case (bscf_pkg::t_action'(i_action))
                        bscf_pkg::ACT_GET,
                        bscf_pkg::ACT_SET,
                        bscf_pkg::ACT_CLEAR,
                        bscf_pkg::ACT_NEXT_SET,
                        bscf_pkg::ACT_NEXT_CLEAR: n_ptr = i_index[BP_W +: WI_W];
                        bscf_pkg::ACT_LENGTH:     n_ptr = LAST_PTR;
                        default:                  n_ptr = '0;
                    endcase
                end
            end
            ST_RUN: begin
                n_bit = 1'b0;
                n_res = '0;
                n_err = 1'b0;
                case (bscf_pkg::t_action'(r_act))
                    bscf_pkg::ACT_GET: begin
                        finish = 1'b1;
                        n_err  = idx_bad;
                        n_bit  = !idx_bad && cur_word[idx_bp];
                    end
                    bscf_pkg::ACT_SET,
                    bscf_pkg::ACT_CLEAR: begin
                        finish = 1'b1;
                        n_err  = idx_bad;
                        wr_en  = !idx_bad;
                        if (r_act == bscf_pkg::ACT_SET) begin
                            wr_data = cur_word | (WB'(1) << idx_bp);
                        end else begin
                            wr_data = cur_word & ~(WB'(1) << idx_bp);
                        end
                    end
                    bscf_pkg::ACT_SET_RANGE,
                    bscf_pkg::ACT_CLEAR_RANGE: begin
                        if (range_bad) begin
                            finish = 1'b1;
                            n_err  = 1'b1;
                        end else begin
                            wr_en = 1'b1;
                            if (r_act == bscf_pkg::ACT_SET_RANGE) begin
                                wr_data = cur_word | range_mask;
                            end else begin
                                wr_data = cur_word & ~range_mask;
                            end
                            finish = at_last;
                            n_ptr  = r_ptr + 1'b1;
                        end
                    end
                    bscf_pkg::ACT_NEXT_SET,
                    bscf_pkg::ACT_NEXT_CLEAR: begin
                        if (idx_bad) begin
                            finish = 1'b1;
                            n_err  = 1'b1;
                            if (r_act == bscf_pkg::ACT_NEXT_SET) begin
                                n_res = '1;
                            end else begin
                                n_res = RES_W'(r_idx);
                            end
                        end else if (search_word != '0) begin
                            finish = 1'b1;
                            n_res  = RES_W'({r_ptr, f_low_one(search_word)});
                        end else if (at_last) begin
                            finish = 1'b1;
                            if (r_act == bscf_pkg::ACT_NEXT_SET) begin
                                n_res = '1;
                            end else begin
                                n_res = RES_W'(CAPACITY);
                            end
                        end else begin
                            n_ptr = r_ptr + 1'b1;
                        end
                    end
                    bscf_pkg::ACT_COUNT: begin
                        n_acc  = acc_sum;
                        n_res  = acc_sum;
                        finish = at_last;
                        n_ptr  = r_ptr + 1'b1;
                    end
                    bscf_pkg::ACT_LENGTH: begin
                        if (cur_word != '0) begin
                            finish = 1'b1;
                            n_res  = RES_W'({r_ptr, f_high_one(cur_word)}) + 1'b1;
                        end else if (at_zero) begin
                            finish = 1'b1;
                        end else begin
                            n_ptr = r_ptr - 1'b1;
                        end
                    end
                    bscf_pkg::ACT_CLEAR_ALL: begin
                        finish  = 1'b1;
                        clr_all = 1'b1;
                    end
                    default: begin
                        finish = 1'b1;
                        n_err  = 1'b1;
                    end
                endcase
                if (finish) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_bit   <= 1'b0;
            r_res   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_bit   <= n_bit;
            r_res   <= n_res;
            r_err   <= n_err;
        end
        r_act <= n_act;
        r_idx <= n_idx;
        r_end <= n_end;
        r_ptr <= n_ptr;
        r_acc <= n_acc;
    end

    // the store itself; reset and clear all wipe every word at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int i = 0; i < WC; i++) begin
                r_words[i] <= '0;
            end
        end else if (wr_en) begin
            r_words[r_ptr] <= wr_data;
        end
    end

    assign busy           = r_state != ST_IDLE;
    assign o_done         = r_done;
    assign o_bit_value    = r_bit;
    assign o_result_value = r_res;
    assign o_error        = r_err;

endmodule
